// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the telnet option responder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge outside reset
`define TOR_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define TOR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define TOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define TOR_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define TOR_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define TOR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/tor_pkg.sv =====
// types, telnet codes and the terminal type reply table for the option responder
`timescale 1ns / 1ps

package tor_pkg;

	// telnet command codes
	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_SE   = 8'd240;

	// telnet option codes
	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] OPT_SGA   = 8'd3;
	localparam logic [7:0] OPT_TTYPE = 8'd24;

	// destination of a result byte
	localparam logic DEST_TERM = 1'b0;
	localparam logic DEST_PEER = 1'b1;

	// reply burst lengths and the index width that covers them
	localparam int TTYPE_LEN = 10;
	localparam int REPLY_LEN = 3;
	localparam int IDX_W     = 4;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       buffer_end;
	} rx_req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_dest;
		logic       out_last;
	} tx_req_t;

	typedef enum logic [1:0] {
		ACT_DATA   = 2'd0,
		ACT_REPLY3 = 2'd1,
		ACT_TTYPE  = 2'd2
	} act_kind_t;

	// one classified request waiting for the back end
	typedef struct packed {
		act_kind_t  kind;
		logic [7:0] verb;
		logic [7:0] opt;
	} action_t;

	// IAC SB TTYPE IS 'A' 'N' 'S' 'I' IAC SE
	function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		case (idx)
			4'd0:    b = TN_IAC;
			4'd1:    b = TN_SB;
			4'd2:    b = OPT_TTYPE;
			4'd3:    b = 8'd0;
			4'd4:    b = 8'd65;
			4'd5:    b = 8'd78;
			4'd6:    b = 8'd83;
			4'd7:    b = 8'd73;
			4'd8:    b = TN_IAC;
			4'd9:    b = TN_SE;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

// ===== hw/rtl/tor_front.sv =====
// front end: telnet sequence parser that turns received bytes into queued actions
`timescale 1ns / 1ps

module tor_front (
	input  logic            clk,
	input  logic            arst_n,
	input  tor_pkg::rx_req_t rx_data,
	input  logic            rx_valid,
	output logic            rx_ready,
	input  logic            q_ready,
	output logic            push,
	output tor_pkg::action_t push_act
);
	import tor_pkg::*;

	typedef enum logic [3:0] {
		PH_DATA = 4'b0001,
		PH_IAC  = 4'b0010,
		PH_CMD  = 4'b0100,
		PH_SKIP = 4'b1000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [7:0] held_q, held_d;
	logic       accept;
	logic       has_act;
	logic [7:0] b;
	logic       sb_done;

	assign rx_ready = q_ready;
	assign accept   = rx_valid && rx_ready;
	assign b        = rx_data.rx_byte;
	assign sb_done  = (b == TN_SE) || rx_data.buffer_end;

	always_comb begin
		phase_d       = phase_q;
		held_d        = held_q;
		has_act       = 1'b0;
		push_act.kind = ACT_DATA;
		push_act.verb = TN_IAC;
		push_act.opt  = b;
		case (phase_q)
			PH_DATA: begin
				if (b == TN_IAC) begin
					phase_d = PH_IAC;
				end else begin
					has_act = 1'b1;
				end
			end
			PH_IAC: begin
				held_d  = b;
				phase_d = PH_CMD;
			end
			PH_CMD: begin
				phase_d = PH_DATA;
				if (held_q == TN_DO && (b == OPT_SGA || b == OPT_TTYPE)) begin
					has_act       = 1'b1;
					push_act.kind = ACT_REPLY3;
					push_act.verb = TN_WILL;
				end else if (held_q == TN_WILL || held_q == TN_WONT) begin
					has_act       = 1'b1;
					push_act.kind = ACT_REPLY3;
					push_act.verb = (b inside {OPT_ECHO, OPT_SGA, OPT_TTYPE}) ? TN_DO : TN_DONT;
				end else if (held_q == TN_DO || held_q == TN_DONT) begin
					has_act       = 1'b1;
					push_act.kind = ACT_REPLY3;
					push_act.verb = TN_WONT;
				end else if (held_q == TN_SB) begin
					if (sb_done) begin
						has_act       = 1'b1;
						push_act.kind = ACT_TTYPE;
					end else begin
						phase_d = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				if (sb_done) begin
					phase_d       = PH_DATA;
					has_act       = 1'b1;
					push_act.kind = ACT_TTYPE;
				end
			end
			default: begin
				phase_d = PH_DATA;
			end
		endcase
	end

	assign push = accept && has_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			held_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

// ===== hw/rtl/tor_cmd_fifo.sv =====
// small action queue between the parser and the reply generator
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tor_cmd_fifo #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tor_pkg::action_t push_act,
	output logic             ready,
	output logic             head_valid,
	output tor_pkg::action_t head,
	input  logic             pop
);
	import tor_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	action_t         mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign ready      = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`TOR_ASSERT_IMPLIES(a_no_push_full, clk, arst_n, push, count_q != CW'(DEPTH))
	`TOR_ASSERT_IMPLIES(a_no_pop_empty, clk, arst_n, pop, count_q != '0)
	`TOR_ASSERT_ALWAYS(a_count_range, clk, arst_n, count_q <= CW'(DEPTH))

endmodule

// ===== hw/rtl/tor_back.sv =====
// back end: expands queued actions into result bytes behind an output register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tor_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  tor_pkg::action_t head,
	output logic             pop,
	output tor_pkg::tx_req_t tx_data,
	output logic             tx_valid,
	input  logic             tx_ready
);
	import tor_pkg::*;

	logic [IDX_W-1:0] idx_q;
	tx_req_t          out_q;
	logic             out_valid_q;
	tx_req_t          gen;
	logic             load;

	always_comb begin
		gen.out_byte = head.opt;
		gen.out_dest = DEST_PEER;
		gen.out_last = 1'b1;
		case (head.kind)
			ACT_DATA: begin
				gen.out_dest = DEST_TERM;
			end
			ACT_REPLY3: begin
				if (idx_q == '0) begin
					gen.out_byte = TN_IAC;
				end else if (idx_q == IDX_W'(1)) begin
					gen.out_byte = head.verb;
				end
				gen.out_last = (idx_q == IDX_W'(REPLY_LEN - 1));
			end
			ACT_TTYPE: begin
				gen.out_byte = ttype_byte(idx_q);
				gen.out_last = (idx_q == IDX_W'(TTYPE_LEN - 1));
			end
			default: begin
				gen.out_dest = DEST_TERM;
			end
		endcase
	end

	// a new byte enters the output register when it is empty or being drained
	assign load     = head_valid && (!out_valid_q || tx_ready);
	assign pop      = load && gen.out_last;
	assign tx_data  = out_q;
	assign tx_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= gen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= gen.out_last ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (tx_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TOR_ASSERT_ALWAYS(a_idx_range, clk, arst_n, idx_q <= IDX_W'(TTYPE_LEN - 1))
	`TOR_ASSERT_IMPLIES(a_data_single, clk, arst_n, head_valid && head.kind == ACT_DATA, idx_q == '0)
	`TOR_ASSERT_IMPLIES(a_reply3_range, clk, arst_n, head_valid && head.kind == ACT_REPLY3, idx_q <= IDX_W'(REPLY_LEN - 1))
	`TOR_ASSERT_IMPLIES(a_term_last, clk, arst_n, out_valid_q && out_q.out_dest == DEST_TERM, out_q.out_last)

endmodule

// ===== hw/rtl/telnet_option_responder.sv =====
// an action passes the action queue and the output register on its way to tx;
// one rx byte per cycle while the action queue (QUEUE_DEPTH entries) has room,
// one tx byte per cycle while tx_ready holds and an action waits; a 3-byte or
// 10-byte reply holds the reply generator until its last byte is loaded
// reset: asynchronous, clears parser phase, held command, queue pointers and tx valid
`timescale 1ns / 1ps

module telnet_option_responder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tor_pkg::rx_req_t rx_data,
	input  logic             rx_valid,
	output logic             rx_ready,
	output tor_pkg::tx_req_t tx_data,
	output logic             tx_valid,
	input  logic             tx_ready
);
	import tor_pkg::*;

	// parser to queue
	logic    q_ready;
	logic    push;
	action_t push_act;

	// queue to reply generator
	logic    head_valid;
	action_t head;
	logic    pop;

	// front end: tracks IAC / command / subnegotiation phase and classifies each byte
	// into pass-through data, a 3-byte option answer or the terminal type reply;
	// bytes that produce nothing (IAC, command bytes, skipped subnegotiation) are
	// consumed without touching the queue
	tor_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_data  (rx_data),
		.rx_valid (rx_valid),
		.rx_ready (rx_ready),
		.q_ready  (q_ready),
		.push     (push),
		.push_act (push_act)
	);

	// queue: absorbs reply bursts so the parser keeps taking bytes
	tor_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_act   (push_act),
		.ready      (q_ready),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// back end: walks the head action one byte per cycle into the output register while
	// it is empty or being drained, and pops it with the byte flagged last
	tor_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tx_data    (tx_data),
		.tx_valid   (tx_valid),
		.tx_ready   (tx_ready)
	);

endmodule
